// ===== hw/rtl/bgc_pkg.sv =====
// Shared types and constants of the bar gauge cell updater.
package bgc_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_CELLS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CELLS_REG_W = 7;
  localparam int unsigned TARGET_W    = 16;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CNT_W       = 7;

  // Depth of the command queue between the front and back ends.
  localparam int unsigned FIFO_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FULL_SCALE = 1'b0,
    REG_CELL_COUNT = 1'b1
  } cfg_reg_e;

  // One classified update, handed from the front end to the back end.
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    hi;
    logic                clr;
    logic                events;
    logic                changed;
  } cmd_t;

endpackage

// ===== hw/rtl/bgc_if.sv =====
// Valid/ready channel interfaces for gauge updates and cell events.
interface bgc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bgc_pkg::DATA_W-1:0]    new_value;
  logic                          rebuild;
  logic [bgc_pkg::TARGET_W-1:0]  target_id;

  modport source (output valid, new_value, rebuild, target_id, input ready);
  modport sink   (input valid, new_value, rebuild, target_id, output ready);
endinterface

interface bgc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bgc_pkg::TARGET_W-1:0]  target_out;
  logic                          cell_valid;
  logic [bgc_pkg::IDX_W-1:0]     cell_index;
  logic                          clearing;
  logic                          changed;
  logic                          last;

  modport source (output valid, target_out, cell_valid, cell_index, clearing, changed, last,
                  input ready);
  modport sink   (input valid, target_out, cell_valid, cell_index, clearing, changed, last,
                  output ready);
endinterface

// ===== hw/rtl/bgc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module bgc_div #(
  parameter int unsigned DW = 23
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [bgc_pkg::DATA_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [DW-1:0]              quotient_o
);
  import bgc_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // One shift-and-subtract step.
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d  = {quo_q[DW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/bgc_front.sv =====
// Front end: configuration, value scaling, rounding and update classification.
module bgc_front #(
  parameter int unsigned MAX_CELLS  = bgc_pkg::MAX_CELLS_DEF,
  parameter int unsigned VALUE_BITS = bgc_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bgc_in_if.sink                     in_i,
  input  logic                       cfg_we_i,
  input  bgc_pkg::cfg_reg_e          cfg_index_i,
  input  logic [bgc_pkg::DATA_W-1:0] cfg_data_i,
  output logic                       push_o,
  output bgc_pkg::cmd_t              cmd_o,
  input  logic                       full_i
);
  import bgc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CELLS + 1);
  localparam int unsigned PW = VALUE_BITS + CW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [DATA_W-1:0]      full_scale_q;
  logic [CELLS_REG_W-1:0] cell_count_q;
  logic [VALUE_BITS-1:0]  prev_q;
  logic [VALUE_BITS-1:0]  val_q;
  logic [VALUE_BITS-1:0]  prev_item_q;
  logic                   rebuild_q;
  logic [TARGET_W-1:0]    target_q;
  logic [CW-1:0]          cells_q;

  logic                   accept;
  logic [VALUE_BITS-1:0]  val_in;
  logic [CW-1:0]          cells_now;
  logic [PW-1:0]          prod_new, prod_old;
  logic                   busy_new, busy_old;
  logic [PW-1:0]          quo_new, quo_old;
  logic [PW-1:0]          qn, qo, cn_w, co_w;
  logic [CW-1:0]          cn, co;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign val_in     = in_i.new_value[VALUE_BITS-1:0];
  assign cells_now  = (cell_count_q > CELLS_REG_W'(MAX_CELLS)) ? CW'(MAX_CELLS)
                                                               : cell_count_q[CW-1:0];

  // Scale both values by the cell count; the dividers register the products.
  assign prod_new = PW'(val_in) * PW'(cells_now);
  assign prod_old = PW'(prev_q) * PW'(cells_now);

  bgc_div #(.DW(PW)) u_div_new (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (prod_new),
    .divisor_i  (full_scale_q),
    .busy_o     (busy_new),
    .quotient_o (quo_new)
  );

  bgc_div #(.DW(PW)) u_div_old (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (prod_old),
    .divisor_i  (full_scale_q),
    .busy_o     (busy_old),
    .quotient_o (quo_old)
  );

  // Rounding rules and saturation of both counts.
  always_comb begin
    qn   = (full_scale_q == '0) ? '0 : quo_new;
    qo   = (full_scale_q == '0) ? '0 : quo_old;
    cn_w = qn;
    co_w = qo;
    if (prev_item_q == '0) begin
      if ((val_q != '0) && (qn == '0)) cn_w = PW'(1);
    end else if (qn == '0) begin
      if (qo == '0) co_w = PW'(1);
      cn_w = (val_q != '0) ? PW'(1) : '0;
    end
    cn = (cn_w > PW'(cells_q)) ? cells_q : cn_w[CW-1:0];
    co = (co_w > PW'(cells_q)) ? cells_q : co_w[CW-1:0];
  end

  // Classify the update into a cell range or a status-only result.
  always_comb begin
    cmd_o.target  = target_q;
    cmd_o.lo      = '0;
    cmd_o.hi      = CNT_W'(cn);
    cmd_o.clr     = 1'b0;
    cmd_o.changed = 1'b1;
    cmd_o.events  = (target_q != '0) && (cn != '0);
    if (!rebuild_q) begin
      if (co == cn) begin
        cmd_o.changed = 1'b0;
        cmd_o.events  = 1'b0;
      end else begin
        cmd_o.events = (target_q != '0);
        if (cn > co) begin
          cmd_o.lo = CNT_W'(co);
          cmd_o.hi = CNT_W'(cn);
        end else begin
          cmd_o.lo  = CNT_W'(cn);
          cmd_o.hi  = CNT_W'(co);
          cmd_o.clr = 1'b1;
        end
      end
    end
  end

  assign push_o = (state_q == ST_PUSH) && !full_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!busy_new && !busy_old) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and stored previous value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      full_scale_q <= DATA_W'(1);
      cell_count_q <= CELLS_REG_W'(8);
      prev_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FULL_SCALE: full_scale_q <= cfg_data_i;
          REG_CELL_COUNT: cell_count_q <= cfg_data_i[CELLS_REG_W-1:0];
          default: ;
        endcase
      end
      if (accept) prev_q <= val_in;
    end
  end

  // Item payload captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q       <= val_in;
      prev_item_q <= prev_q;
      rebuild_q   <= in_i.rebuild;
      target_q    <= in_i.target_id;
      cells_q     <= cells_now;
    end
  end

endmodule

// ===== hw/rtl/bgc_fifo.sv =====
// Small command queue between the front and back ends.
module bgc_fifo #(
  parameter int unsigned DEPTH = bgc_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bgc_pkg::cmd_t data_o,
  output logic          empty_o
);
  import bgc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  cmd_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_QW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      if (do_pop)  rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_QW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_QW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/bgc_back.sv =====
// Back end: walks a command's cell range and emits one result per cycle while the output is ready.
module bgc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  bgc_pkg::cmd_t cmd_i,
  output logic          pop_o,
  bgc_out_if.source     out_o
);
  import bgc_pkg::*;

  logic                ov_q;
  logic                started_q;
  logic [CNT_W-1:0]    idx_q;
  logic [TARGET_W-1:0] target_q;
  logic                cell_valid_q, clearing_q, changed_q, last_q;
  logic [IDX_W-1:0]    cell_index_q;

  logic                load;
  logic [CNT_W-1:0]    cur;
  logic [CNT_W-1:0]    nxt;
  logic                is_last;

  // A new result enters the output register when it is free or being drained.
  assign load    = !empty_i && (!ov_q || out_o.ready);
  assign cur     = started_q ? idx_q : cmd_i.lo;
  assign nxt     = cur + CNT_W'(1);
  assign is_last = !cmd_i.events || (nxt == cmd_i.hi);
  assign pop_o   = load && is_last;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      started_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        ov_q      <= 1'b1;
        started_q <= !is_last;
        idx_q     <= nxt;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      target_q     <= cmd_i.target;
      cell_valid_q <= cmd_i.events;
      cell_index_q <= cmd_i.events ? cur[IDX_W-1:0] : '0;
      clearing_q   <= cmd_i.events && cmd_i.clr;
      changed_q    <= cmd_i.changed;
      last_q       <= is_last;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.target_out = target_q;
  assign out_o.cell_valid = cell_valid_q;
  assign out_o.cell_index = cell_index_q;
  assign out_o.clearing   = clearing_q;
  assign out_o.changed    = changed_q;
  assign out_o.last       = last_q;

endmodule

// ===== hw/rtl/bar_gauge_cell_updater_top.sv =====
// Top level of the bar gauge cell updater.
//
//   Channel   Direction  Handshake             Carries
//   in_i      in         valid/ready           new_value, rebuild, target_id
//   out_o     out        valid/ready           target_out, cell_valid, cell_index,
//                                              clearing, changed, last
//   cfg       in         cfg_we_i, no wait     full_scale (index 0), cell_count (index 1)
//
// The front end takes one update at a time; its scaling is done by the two bit-serial
// dividers running side by side.
// The back end sends one result per cycle while out_o is ready, one to MAX_CELLS per update.
// A two-entry command queue lets the front end scale the next update while results drain.
// Reset is asynchronous and needs no clearing pass; a stalled output holds its result.
module bar_gauge_cell_updater_top #(
  parameter int unsigned MAX_CELLS  = bgc_pkg::MAX_CELLS_DEF,
  parameter int unsigned VALUE_BITS = bgc_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bgc_in_if.sink                     in_i,
  bgc_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  bgc_pkg::cfg_reg_e          cfg_index_i,
  input  logic [bgc_pkg::DATA_W-1:0] cfg_data_i
);
  import bgc_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  // Scaling and classification.
  bgc_front #(
    .MAX_CELLS  (MAX_CELLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .full_i      (full)
  );

  // Command queue.
  bgc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  // Event generation.
  bgc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== sim/bar_gauge_cell_updater_top_tb.sv =====
// Self-checking testbench of the bar gauge cell updater, with its own predictor.
module bar_gauge_cell_updater_top_tb;
  import bgc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned MAX_REPORTS   = 10;

  // One gauge update as offered on the input channel.
  typedef struct {
    logic [DATA_W-1:0]   value;
    logic                rebuild;
    logic [TARGET_W-1:0] target;
  } gauge_update_t;

  // One cell event or status result as seen on the output channel.
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic                cell_valid;
    logic [IDX_W-1:0]    cell_index;
    logic                clearing;
    logic                changed;
    logic                last;
  } cell_event_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_reg_e            cfg_index_i;
  logic [DATA_W-1:0]   cfg_data_i;

  bgc_in_if  upd_if ();
  bgc_out_if evt_if ();

  bar_gauge_cell_updater_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (upd_if),
    .out_o       (evt_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copies of the registers and of the stored gauge value.
  logic [DATA_W-1:0]      cfg_full_scale;
  logic [CELLS_REG_W-1:0] cfg_cells;
  logic [DATA_W-1:0]      gauge_prev;
  logic [DATA_W-1:0]      last_queued_value;

  gauge_update_t pending_updates_q[$];
  cell_event_t   expected_events_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  // Free-running clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Lit-cell count of a value at the current full scale.
  function automatic int unsigned scaled_count(input logic [DATA_W-1:0] value,
                                               input int unsigned cells);
    if (cfg_full_scale == '0) begin
      return 0;
    end
    return (value * cells) / cfg_full_scale;
  endfunction

  function automatic void push_event(input logic [TARGET_W-1:0] target, input logic cell_valid,
                                     input int unsigned index, input logic clearing,
                                     input logic changed, input logic last);
    cell_event_t ev;
    ev.target     = target;
    ev.cell_valid = cell_valid;
    ev.cell_index = index[IDX_W-1:0];
    ev.clearing   = clearing;
    ev.changed    = changed;
    ev.last       = last;
    expected_events_q.push_back(ev);
  endfunction

  // Works out the cell events that one accepted update causes.
  function automatic void predict_cell_events(input logic [DATA_W-1:0] value,
                                              input logic rebuild,
                                              input logic [TARGET_W-1:0] target);
    int unsigned cells;
    int unsigned old_cnt;
    int unsigned new_cnt;
    int unsigned lo;
    int unsigned hi;
    logic        clr;
    cells   = (cfg_cells > MAX_CELLS_DEF) ? MAX_CELLS_DEF : cfg_cells;
    old_cnt = scaled_count(gauge_prev, cells);
    new_cnt = scaled_count(value, cells);

    // A nonzero value shows a cell unless the gauge has none; a gauge that was lit shows one to clear.
    if (gauge_prev == '0) begin
      if (value != '0 && new_cnt == 0) begin
        new_cnt = 1;
      end
    end else if (new_cnt == 0) begin
      if (old_cnt == 0) begin
        old_cnt = 1;
      end
      if (value != '0) begin
        new_cnt = 1;
      end
    end
    if (old_cnt > cells) begin
      old_cnt = cells;
    end
    if (new_cnt > cells) begin
      new_cnt = cells;
    end
    gauge_prev = value;

    if (rebuild) begin
      lo  = 0;
      hi  = new_cnt;
      clr = 1'b0;
    end else if (old_cnt == new_cnt) begin
      push_event(target, 1'b0, 0, 1'b0, 1'b0, 1'b1);
      return;
    end else if (new_cnt > old_cnt) begin
      lo  = old_cnt;
      hi  = new_cnt;
      clr = 1'b0;
    end else begin
      lo  = new_cnt;
      hi  = old_cnt;
      clr = 1'b1;
    end

    if (target == '0 || lo >= hi) begin
      push_event(target, 1'b0, 0, 1'b0, 1'b1, 1'b1);
    end else begin
      for (int unsigned i = lo; i < hi; i++) begin
        push_event(target, 1'b1, i, clr, 1'b1, (i + 1 == hi));
      end
    end
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Input driver: predicts each accepted transaction, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (upd_if.valid && upd_if.ready) begin
        predict_cell_events(upd_if.new_value, upd_if.rebuild, upd_if.target_id);
      end
      if (!upd_if.valid || upd_if.ready) begin
        if (pending_updates_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          upd_if.valid     <= 1'b1;
          upd_if.new_value <= pending_updates_q[0].value;
          upd_if.rebuild   <= pending_updates_q[0].rebuild;
          upd_if.target_id <= pending_updates_q[0].target;
          void'(pending_updates_q.pop_front());
        end else begin
          upd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        if (expected_events_q.size() == 0) begin
          note_error($sformatf({"unexpected result: target %h cell_valid %b index %0d ",
                                "clr %b chg %b last %b"},
                               evt_if.target_out, evt_if.cell_valid, evt_if.cell_index,
                               evt_if.clearing, evt_if.changed, evt_if.last));
        end else begin
          if (evt_if.target_out !== expected_events_q[0].target ||
              evt_if.cell_valid !== expected_events_q[0].cell_valid ||
              evt_if.cell_index !== expected_events_q[0].cell_index ||
              evt_if.clearing   !== expected_events_q[0].clearing ||
              evt_if.changed    !== expected_events_q[0].changed ||
              evt_if.last       !== expected_events_q[0].last) begin
            note_error($sformatf({"result mismatch: expected target %h valid %b index %0d clr %b ",
                                  "chg %b last %b, got target %h valid %b index %0d clr %b ",
                                  "chg %b last %b"},
                                 expected_events_q[0].target, expected_events_q[0].cell_valid,
                                 expected_events_q[0].cell_index, expected_events_q[0].clearing,
                                 expected_events_q[0].changed, expected_events_q[0].last,
                                 evt_if.target_out, evt_if.cell_valid, evt_if.cell_index,
                                 evt_if.clearing, evt_if.changed, evt_if.last));
          end
          void'(expected_events_q.pop_front());
        end
      end
      evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** bar_gauge_cell_updater_top: FAILED **");
      $finish;
    end
  end

  task automatic queue_update(input logic [DATA_W-1:0] value, input logic rebuild,
                              input logic [TARGET_W-1:0] target);
    gauge_update_t upd;
    upd.value   = value;
    upd.rebuild = rebuild;
    upd.target  = target;
    pending_updates_q.push_back(upd);
    last_queued_value = value;
  endtask

  // Random updates, weighted toward values that spread over the gauge, with zeros, small values and repeats.
  task automatic queue_random_updates(input int unsigned count);
    logic [DATA_W-1:0]   value;
    logic [TARGET_W-1:0] target;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0:       value = '0;
        1:       value = DATA_W'($urandom_range(3));
        2:       value = last_queued_value;
        3, 4:    value = DATA_W'($urandom_range(16'hFFFF));
        default: value = (cfg_full_scale == '0) ? DATA_W'($urandom_range(16'hFFFF))
                                                : DATA_W'($urandom_range(cfg_full_scale));
      endcase
      target = ($urandom_range(7) == 0) ? '0 : TARGET_W'($urandom_range(16'hFFFF, 1));
      queue_update(value, ($urandom_range(3) == 0), target);
    end
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_config(input logic [DATA_W-1:0] full_scale,
                              input logic [CELLS_REG_W-1:0] cells);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FULL_SCALE;
    cfg_data_i  <= full_scale;
    @(posedge clk_i);
    cfg_index_i <= REG_CELL_COUNT;
    cfg_data_i  <= DATA_W'(cells);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_full_scale = full_scale;
    cfg_cells      = cells;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic wait_until_quiet();
    while (pending_updates_q.size() != 0 || upd_if.valid || expected_events_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Phase table: register settings and idling mode of each random phase.
  int unsigned phase_full_scale[8] = '{100, 65535, 0, 1000, 5000, 300, 40000, 7};
  int unsigned phase_cells[8]      = '{10, 64, 16, 0, 127, 64, 33, 1};
  int unsigned mode_send_pct[4]    = '{0, 80, 0, 8};
  int unsigned mode_recv_pct[4]    = '{0, 0, 80, 8};

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_FULL_SCALE;
    cfg_data_i        = '0;
    upd_if.valid      = 1'b0;
    upd_if.new_value  = '0;
    upd_if.rebuild    = 1'b0;
    upd_if.target_id  = '0;
    evt_if.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    error_count       = 0;
    cycle_count       = 0;
    cfg_full_scale    = 16'd1;
    cfg_cells         = 7'd8;
    gauge_prev        = '0;
    last_queued_value = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: any nonzero value fills all eight cells, then all clear and fill again.
    queue_update(16'h0001, 1'b1, 16'h5555);
    queue_update(16'h0000, 1'b0, 16'hFFFF);
    queue_update(16'hFFFF, 1'b0, 16'hAAAA);
    wait_until_quiet();

    // Directed cases on a ten-cell gauge: rounding, no change, no target, rebuilds.
    write_config(16'd1000, 7'd10);
    queue_update(16'd0, 1'b0, 16'h0001);
    queue_update(16'd1, 1'b0, 16'hFFFF);
    queue_update(16'd0, 1'b0, 16'h0005);
    queue_update(16'd1, 1'b0, 16'h0005);
    queue_update(16'd2, 1'b0, 16'h0005);
    queue_update(16'hFFFF, 1'b0, 16'h0005);
    queue_update(16'hFFFF, 1'b1, 16'hFFFF);
    queue_update(16'hFFFF, 1'b0, 16'h0000);
    queue_update(16'd500, 1'b0, 16'h0000);
    queue_update(16'd0, 1'b1, 16'h0007);
    queue_update(16'd999, 1'b0, 16'h8000);
    queue_update(16'd1000, 1'b0, 16'h1234);
    queue_update(16'd300, 1'b1, 16'h0000);
    queue_update(16'h8000, 1'b0, 16'hAAAA);
    queue_update(16'd1, 1'b0, 16'h5555);
    queue_update(16'd1, 1'b1, 16'h00FF);
    wait_until_quiet();

    // Extremes: full 64-cell gauge including the top cell, then a long clear and a full rebuild.
    write_config(16'hFFFF, 7'd64);
    queue_update(16'hFFFF, 1'b0, 16'hFF00);
    queue_update(16'h0000, 1'b0, 16'h00FF);
    queue_update(16'hFFFF, 1'b1, 16'h8001);
    wait_until_quiet();

    // Random phases over the settings table, rotating through the idling modes.
    for (int p = 0; p < 8; p++) begin
      write_config(DATA_W'(phase_full_scale[p]), CELLS_REG_W'(phase_cells[p]));
      set_idling(mode_send_pct[p % 4], mode_recv_pct[p % 4]);
      queue_random_updates(45);
      wait_until_quiet();
    end

    // Random settings, small full scales now and then.
    for (int p = 0; p < 4; p++) begin
      write_config(($urandom_range(1) == 0) ? DATA_W'($urandom_range(16'hFFFF))
                                            : DATA_W'($urandom_range(50)),
                   CELLS_REG_W'($urandom_range(127)));
      set_idling(mode_send_pct[p], mode_recv_pct[p]);
      queue_random_updates(30);
      wait_until_quiet();
    end

    if (error_count == 0 && expected_events_q.size() == 0) begin
      $display("** bar_gauge_cell_updater_top: PASSED **");
    end else begin
      $display("** bar_gauge_cell_updater_top: FAILED **");
    end
    $finish;
  end

endmodule
